FILE: design/pdb_pkg.sv
// Shared types and constants for the point density binning block.
`default_nettype none

package pdb_pkg;

    localparam int COORD_W       = 32;
    localparam int PIXEL_W       = 12;
    localparam int COUNT_W       = 32;
    localparam int GRID_W        = 13;
    localparam int LIMIT_W       = 6;
    localparam int LIMIT_CMP_W   = 7;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [GRID_W-1:0] GRID_MAX = GRID_W'(4096);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y    = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_SCALE = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] CFG_FLUSH_LIMIT = CFG_INDEX_W'(5);

    // input command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
    } point_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
        logic [COUNT_W-1:0] bin_count;
        logic               last;
    } bin_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INC,
        CELL_APPEND,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [PIXEL_W-1:0] key_col;
        logic [PIXEL_W-1:0] key_row;
    } cell_ctrl_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] col;
        logic [PIXEL_W-1:0] row;
        logic [COUNT_W-1:0] total;
    } cell_data_t;

endpackage

`default_nettype wire

FILE: design/point_density_binning.sv
// Top level of the point density binning block: control, configuration and cell row.
// Usage:
//   Points arrive on the point channel (point_valid / point_stall, payload point).
//   An add beat maps coord_x / coord_y to a pixel column and row and counts it in a
//   row of TABLE_ENTRIES cells; a flush beat, or an add that pushes the number of
//   used entries past flush_limit, emits every entry in insertion order on the bin
//   channel (bin_valid / bin_stall, payload bin), with last set on the final beat.
//   An add beat holds the block busy while the accept edge registers the origin
//   offset, then the 32x32 multiply, the clamp and the parallel compare/update
//   across the cells follow in turn. A flush emits one bin beat per cycle
//   while the receiver takes them, as the cell row shifts towards cell 0.
//   point_stall is low only while the block is idle, so one point is in work at a
//   time; a result waiting in the output register does not hold off the next point.
//   When bin_stall is high while a beat is waiting, the output beat holds and the cell row stops shifting.
//   Configuration is written through cfg_write / cfg_index / cfg_data while idle.
//   Reset clears the used count, the output register and the state machine and loads
//   the configuration defaults; cell contents are left as they are and never read
//   until written.
`default_nettype none

module point_density_binning #(
    parameter int TABLE_ENTRIES = pdb_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                point_valid,
    output logic                                     point_stall,
    input  wire pdb_pkg::point_t                     point,
    output logic                                     bin_valid,
    input  wire logic                                bin_stall,
    output pdb_pkg::bin_t                            bin,
    input  wire logic                                cfg_write,
    input  wire logic [pdb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pdb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pdb_pkg::*;

    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [LIMIT_CMP_W-1:0] MAX_LIMIT = LIMIT_CMP_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_CLAMP,
        S_LOOK,
        S_EMIT
    } state_t;

    // configuration
    logic signed [COORD_W-1:0] origin_x_reg;
    logic signed [COORD_W-1:0] origin_y_reg;
    logic [COORD_W-1:0]        pixel_scale_reg;
    logic [GRID_W-1:0]         grid_width_reg;
    logic [GRID_W-1:0]         grid_height_reg;
    logic [LIMIT_W-1:0]        flush_limit_reg;

    state_t              state_reg;
    state_t              state_next;
    logic [USED_W-1:0]   used_reg;
    logic [USED_W-1:0]   used_next;
    bin_t                bin_reg;
    bin_t                bin_next;
    logic                bin_valid_reg;
    logic                bin_valid_next;

    logic [PIXEL_W-1:0]       col_pix;
    logic [PIXEL_W-1:0]       row_pix;
    cell_ctrl_t               cell_ctrl;
    cell_data_t               cell_q [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic [TABLE_ENTRIES-1:0] active_vec;
    logic [TABLE_ENTRIES-1:0] slot_vec;

    logic                   point_accept;
    logic                   slot_free;
    logic                   any_hit;
    logic [USED_W-1:0]      used_after;
    logic [LIMIT_CMP_W-1:0] eff_limit;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            pixel_scale_reg <= COORD_W'(65536);
            grid_width_reg  <= GRID_MAX;
            grid_height_reg <= GRID_MAX;
            flush_limit_reg <= '1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                CFG_PIXEL_SCALE: pixel_scale_reg <= cfg_data;
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[GRID_W-1:0];
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[GRID_W-1:0];
                CFG_FLUSH_LIMIT: flush_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pixel mapping, one pipeline per axis. The pipelines run freely;
    // the state machine picks the result off in S_LOOK, once the offset,
    // product and pixel registers have loaded in turn from the accept edge.
    // ---------------------------------------------------------------
    pdb_pixel u_pixel_x (
        .clk       (clk),
        .coord     (point.coord_x),
        .origin    (origin_x_reg),
        .scale     (pixel_scale_reg),
        .grid_size (grid_width_reg),
        .pixel     (col_pix)
    );

    pdb_pixel u_pixel_y (
        .clk       (clk),
        .coord     (point.coord_y),
        .origin    (origin_y_reg),
        .scale     (pixel_scale_reg),
        .grid_size (grid_height_reg),
        .pixel     (row_pix)
    );

    // ---------------------------------------------------------------
    // Cell row. Entry k of the table lives in cell k; on emission the
    // row shifts towards cell 0, which feeds the output register.
    // ---------------------------------------------------------------
    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        cell_data_t shift_in;

        assign active_vec[i] = (used_reg > USED_W'(i));
        assign slot_vec[i]   = (used_reg == USED_W'(i));

        if (i == TABLE_ENTRIES - 1)
        begin : g_tail
            assign shift_in = cell_q[i];
        end
        else
        begin : g_body
            assign shift_in = cell_q[i+1];
        end

        pdb_cell u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl),
            .active   (active_vec[i]),
            .slot_sel (slot_vec[i]),
            .neighbor (shift_in),
            .data     (cell_q[i]),
            .hit      (hit_vec[i])
        );
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    assign point_accept = point_valid && !point_stall;
    assign slot_free    = !bin_valid_reg || !bin_stall;
    assign any_hit      = |hit_vec;

    // the limit never lets the table overflow
    assign eff_limit = (LIMIT_CMP_W'(flush_limit_reg) > MAX_LIMIT) ? MAX_LIMIT
                                                                   : LIMIT_CMP_W'(flush_limit_reg);
    assign used_after = (used_reg < USED_W'(TABLE_ENTRIES)) ? used_reg + USED_W'(1) : used_reg;

    always_comb
    begin
        state_next        = state_reg;
        used_next         = used_reg;
        bin_next          = bin_reg;
        bin_valid_next    = bin_valid_reg && bin_stall;
        cell_ctrl.op      = CELL_HOLD;
        cell_ctrl.key_col = col_pix;
        cell_ctrl.key_row = row_pix;

        case (state_reg)
            S_IDLE:
            begin
                if (point_accept)
                begin
                    if (point.cmd == CMD_FLUSH)
                    begin
                        // an empty table gives no beats
                        if (used_reg != '0)
                            state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (any_hit)
                begin
                    cell_ctrl.op = CELL_INC;
                    state_next   = S_IDLE;
                end
                else
                begin
                    if (used_reg < USED_W'(TABLE_ENTRIES))
                        cell_ctrl.op = CELL_APPEND;
                    used_next = used_after;
                    if (LIMIT_CMP_W'(used_after) > eff_limit)
                        state_next = S_EMIT;
                    else
                        state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                // load cell 0 into the output register and advance the row
                if (slot_free)
                begin
                    bin_next.pixel_x   = cell_q[0].col;
                    bin_next.pixel_y   = cell_q[0].row;
                    bin_next.bin_count = cell_q[0].total;
                    bin_next.last      = (used_reg == USED_W'(1));
                    bin_valid_next     = 1'b1;
                    cell_ctrl.op       = CELL_SHIFT;
                    used_next          = used_reg - USED_W'(1);
                    if (used_reg == USED_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            bin_reg       <= '0;
            bin_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            bin_reg       <= bin_next;
            bin_valid_reg <= bin_valid_next;
        end
    end

    assign point_stall = (state_reg != S_IDLE);
    assign bin_valid   = bin_valid_reg;
    assign bin         = bin_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_idle_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (used_reg < USED_W'(TABLE_ENTRIES)))
        else $error("table full while idle");

    a_unique_bin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |-> $onehot0(hit_vec))
        else $error("more than one cell holds the same bin");

    a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bin_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("output beat raised outside emission");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && slot_free && used_reg == USED_W'(1))
        |=> (state_reg == S_IDLE && used_reg == '0 && bin_valid_reg && bin_reg.last))
        else $error("emission did not end on the last beat");

endmodule

`default_nettype wire

FILE: design/pdb_pixel.sv
// Coordinate to pixel index pipeline: offset, scale, truncate and clamp.
`default_nettype none

module pdb_pixel (
    input  wire logic                                clk,
    input  wire logic signed [pdb_pkg::COORD_W-1:0]  coord,
    input  wire logic signed [pdb_pkg::COORD_W-1:0]  origin,
    input  wire logic [pdb_pkg::COORD_W-1:0]         scale,
    input  wire logic [pdb_pkg::GRID_W-1:0]          grid_size,
    output logic [pdb_pkg::PIXEL_W-1:0]              pixel
);
    import pdb_pkg::*;

    logic [COORD_W:0]     diff_next;
    logic [COORD_W-1:0]   diff_reg;
    logic                 pos_next;
    logic                 pos_reg;
    logic [2*COORD_W-1:0] prod_next;
    logic [COORD_W-1:0]   prod_hi_reg;
    logic                 pos2_reg;
    logic [PIXEL_W-1:0]   lim;
    logic [PIXEL_W-1:0]   pixel_next;
    logic [PIXEL_W-1:0]   pixel_reg;

    // exact 33-bit difference; only positive offsets give a nonzero index
    assign diff_next = {coord[COORD_W-1], coord} - {origin[COORD_W-1], origin};
    assign pos_next  = !diff_next[COORD_W] && (diff_next != '0);

    assign prod_next = diff_reg * scale;

    always_comb
    begin
        if (grid_size == '0)
            lim = '0;
        else if (grid_size > GRID_MAX)
            lim = '1;
        else
            lim = PIXEL_W'(grid_size - GRID_W'(1));
    end

    always_comb
    begin
        if (!pos2_reg)
            pixel_next = '0;
        else if (prod_hi_reg > COORD_W'(lim))
            pixel_next = lim;
        else
            pixel_next = prod_hi_reg[PIXEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        diff_reg    <= diff_next[COORD_W-1:0];
        pos_reg     <= pos_next;
        prod_hi_reg <= prod_next[2*COORD_W-1:COORD_W];
        pos2_reg    <= pos_reg;
        pixel_reg   <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule

`default_nettype wire

FILE: design/pdb_cell.sv
// One table cell: holds a bin, matches the key, counts, appends and shifts.
`default_nettype none

module pdb_cell (
    input  wire logic                 clk,
    input  wire pdb_pkg::cell_ctrl_t  ctrl,
    input  wire logic                 active,
    input  wire logic                 slot_sel,
    input  wire pdb_pkg::cell_data_t  neighbor,
    output pdb_pkg::cell_data_t       data,
    output logic                      hit
);
    import pdb_pkg::*;

    cell_data_t data_reg;
    cell_data_t data_next;

    assign hit = active && (data_reg.col == ctrl.key_col) && (data_reg.row == ctrl.key_row);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_SHIFT:
            begin
                data_next = neighbor;
            end
            CELL_APPEND:
            begin
                if (slot_sel)
                begin
                    data_next.col   = ctrl.key_col;
                    data_next.row   = ctrl.key_row;
                    data_next.total = COUNT_W'(1);
                end
            end
            CELL_INC:
            begin
                // saturate at all ones
                if (hit && (data_reg.total != '1))
                    data_next.total = data_reg.total + COUNT_W'(1);
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

FILE: tb/pdb_bin_checker.sv
// Scoreboard for the point density binning block: predicts bin beats and checks them in order.
`timescale 1ns / 1ps

module pdb_bin_checker #(
    parameter int TABLE_ENTRIES = pdb_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               point_valid,
    input  logic                               point_stall,
    input  pdb_pkg::point_t                    point_beat,
    input  logic                               bin_valid,
    input  logic                               bin_stall,
    input  pdb_pkg::bin_t                      bin_beat,
    input  logic                               cfg_write,
    input  logic [pdb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pdb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                 mismatches,
    output int                                 waiting,
    output int                                 points_taken,
    output int                                 bins_taken
);

    import pdb_pkg::*;

    // shadow copy of the configuration registers
    logic signed [COORD_W-1:0] base_x;
    logic signed [COORD_W-1:0] base_y;
    logic [COORD_W-1:0]        scale;
    logic [GRID_W-1:0]         cols;
    logic [GRID_W-1:0]         rows;
    logic [LIMIT_W-1:0]        limit;

    // occupied bins in insertion order
    logic [PIXEL_W-1:0] slot_col   [TABLE_ENTRIES];
    logic [PIXEL_W-1:0] slot_row   [TABLE_ENTRIES];
    logic [COUNT_W-1:0] slot_count [TABLE_ENTRIES];
    int                 slots_used;

    bin_t bins_due [$];
    bin_t want;

    // Offset by the origin, scale by the Q16.16 reciprocal, truncate and clamp.
    function automatic logic [PIXEL_W-1:0] pixel_of(input logic signed [COORD_W-1:0] coord,
                                                   input logic signed [COORD_W-1:0] base,
                                                   input logic [GRID_W-1:0] size);
        logic signed [COORD_W+1:0] offset;
        logic [2*COORD_W-1:0]      product;
        logic [GRID_W-1:0]         span;
        if (size == '0)
            span = GRID_W'(1);
        else if (size > GRID_MAX)
            span = GRID_MAX;
        else
            span = size;
        offset = $signed({{2{coord[COORD_W-1]}}, coord}) - $signed({{2{base[COORD_W-1]}}, base});
        if (offset <= 0)
            return '0;
        product = {{COORD_W{1'b0}}, offset[COORD_W-1:0]} * {{COORD_W{1'b0}}, scale};
        if (product[2*COORD_W-1:COORD_W] >= {{(COORD_W-GRID_W){1'b0}}, span})
            return PIXEL_W'(span - 1'b1);
        return product[COORD_W +: PIXEL_W];
    endfunction

    function automatic void flush_table();
        bin_t beat;
        for (int k = 0; k < slots_used; k++)
        begin
            beat.pixel_x   = slot_col[k];
            beat.pixel_y   = slot_row[k];
            beat.bin_count = slot_count[k];
            beat.last      = (k == slots_used - 1);
            bins_due.push_back(beat);
        end
        slots_used = 0;
    endfunction

    function automatic void count_point(input point_t p);
        logic [PIXEL_W-1:0] col;
        logic [PIXEL_W-1:0] row;
        int                 cap;
        if (p.cmd == CMD_FLUSH)
        begin
            flush_table();
            return;
        end
        col = pixel_of(p.coord_x, base_x, cols);
        row = pixel_of(p.coord_y, base_y, rows);
        for (int k = 0; k < slots_used; k++)
        begin
            if (slot_col[k] == col && slot_row[k] == row)
            begin
                if (slot_count[k] != '1)
                    slot_count[k] = slot_count[k] + 1'b1;
                return;
            end
        end
        if (slots_used < TABLE_ENTRIES)
        begin
            slot_col[slots_used]   = col;
            slot_row[slots_used]   = row;
            slot_count[slots_used] = COUNT_W'(1);
            slots_used++;
        end
        cap = (int'(limit) > TABLE_ENTRIES - 1) ? TABLE_ENTRIES - 1 : int'(limit);
        if (slots_used > cap)
            flush_table();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_x       = '0;
            base_y       = '0;
            scale        = COORD_W'(65536);
            cols         = GRID_MAX;
            rows         = GRID_MAX;
            limit        = LIMIT_W'(63);
            slots_used   = 0;
            bins_due.delete();
            mismatches   = 0;
            waiting      = 0;
            points_taken = 0;
            bins_taken   = 0;
        end
        else
        begin
            // check outgoing beats first, so a beat never meets an expectation queued this edge
            if (bin_valid && !bin_stall)
            begin
                bins_taken++;
                if (bins_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected bin beat x=%0d y=%0d count=%0d last=%0b",
                                 $time, bin_beat.pixel_x, bin_beat.pixel_y,
                                 bin_beat.bin_count, bin_beat.last);
                    mismatches++;
                end
                else
                begin
                    want = bins_due.pop_front();
                    if (bin_beat.pixel_x !== want.pixel_x || bin_beat.pixel_y !== want.pixel_y ||
                        bin_beat.bin_count !== want.bin_count || bin_beat.last !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: bin beat mismatch: expected x=%0d y=%0d count=%0d ",
                                      "last=%0b, got x=%0d y=%0d count=%0d last=%0b"},
                                     $time, want.pixel_x, want.pixel_y, want.bin_count,
                                     want.last, bin_beat.pixel_x, bin_beat.pixel_y,
                                     bin_beat.bin_count, bin_beat.last);
                        mismatches++;
                    end
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ORIGIN_X:    base_x = cfg_data;
                    CFG_ORIGIN_Y:    base_y = cfg_data;
                    CFG_PIXEL_SCALE: scale  = cfg_data;
                    CFG_GRID_WIDTH:  cols   = cfg_data[GRID_W-1:0];
                    CFG_GRID_HEIGHT: rows   = cfg_data[GRID_W-1:0];
                    CFG_FLUSH_LIMIT: limit  = cfg_data[LIMIT_W-1:0];
                    default:         ;
                endcase
            end

            if (point_valid && !point_stall)
            begin
                points_taken++;
                count_point(point_beat);
            end

            waiting = bins_due.size();
        end
    end

endmodule

FILE: tb/point_density_binning_test.sv
// Top of the point density binning testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module point_density_binning_test;

    import pdb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;     // long enough for an add beat to finish
    localparam int LONG_HOLD     = 400;
    // an index past the last register: writes to it must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(7);

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   point_valid = 1'b0;
    logic                   point_stall;
    point_t                 pt_beat     = '0;
    logic                   bin_valid;
    logic                   bin_stall   = 1'b0;
    bin_t                   bin_beat;
    logic                   cfg_write   = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    int mismatches;
    int waiting;
    int points_taken;
    int bins_taken;
    int cycle_count   = 0;
    int settings_used = 1;     // the reset defaults count as the first setting

    // idling switches and the long hold-off request, set by the main sequence for the two drivers
    bit send_gaps   = 1'b1;
    bit take_gaps   = 1'b1;
    int hold_cycles = 0;

    // current grid, kept so that random points can be aimed at it
    logic [COORD_W-1:0] aim_x     = '0;
    logic [COORD_W-1:0] aim_y     = '0;
    logic [COORD_W-1:0] aim_scale = COORD_W'(65536);
    logic [GRID_W-1:0]  aim_cols  = GRID_MAX;
    logic [GRID_W-1:0]  aim_rows  = GRID_MAX;

    point_density_binning u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (pt_beat),
        .bin_valid   (bin_valid),
        .bin_stall   (bin_stall),
        .bin         (bin_beat),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    pdb_bin_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_beat   (pt_beat),
        .bin_valid    (bin_valid),
        .bin_stall    (bin_stall),
        .bin_beat     (bin_beat),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .points_taken (points_taken),
        .bins_taken   (bins_taken)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the block stops making progress.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d bin beats still due", cycle_count, waiting);
        $display("** point_density_binning: FAILED **");
        $finish;
    end

    // Receiver: stall in random bursts, or hold off for a long stretch when asked.
    // Every stall change happens at the falling edge, once per step.
    initial
    begin
        int burst;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                bin_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
                bin_stall <= 1'b0;
            end
            else if (take_gaps && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 11);
                bin_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                bin_stall <= 1'b0;
            end
            else
                bin_stall <= 1'b0;
        end
    end

    // Offer one point beat and hold it until the block takes it. Called at a falling
    // edge; leave valid high on return so back-to-back beats need no extra step.
    task automatic offer_point(input logic op, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            point_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        point_valid <= 1'b1;
        pt_beat     <= '{cmd: op, coord_x: x, coord_y: y};
        @(posedge clk);
        while (point_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // Load a whole grid setting. Narrow registers get random junk above their width,
    // which the block must ignore.
    task automatic set_grid(input logic [COORD_W-1:0] ox, oy, sc,
                            input logic [GRID_W-1:0] gw, gh,
                            input logic [LIMIT_W-1:0] lim);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_PIXEL_SCALE, sc);
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'($urandom() << GRID_W) | CFG_DATA_W'(gw));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'($urandom() << GRID_W) | CFG_DATA_W'(gh));
        write_reg(CFG_FLUSH_LIMIT, CFG_DATA_W'($urandom() << LIMIT_W) | CFG_DATA_W'(lim));
        aim_x     = ox;
        aim_y     = oy;
        aim_scale = sc;
        aim_cols  = gw;
        aim_rows  = gh;
        settings_used++;
    endtask

    // Drop valid and wait until every predicted bin has left, then give the block
    // time to finish an add that produced nothing.
    task automatic drain_bins();
        point_valid <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly land on or near the grid, starting a little below its origin; now and then any value at all.
    function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] base,
                                                     input logic [GRID_W-1:0] cells);
        longint reach;
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        reach = ((longint'(cells) + 1) << 32) / longint'(aim_scale == 0 ? 1 : aim_scale);
        if (reach > 64'sh7FFF_FFFF)
            reach = 64'sh7FFF_FFFF;
        return base + COORD_W'($urandom_range(32'(reach), 0)) - COORD_W'(reach / 16);
    endfunction

    task automatic random_points(input int count, input int flush_pct);
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 99) < flush_pct)
                offer_point(CMD_FLUSH, $urandom(), $urandom());
            else
                offer_point(CMD_ADD, pick_coord(aim_x, aim_cols), pick_coord(aim_y, aim_rows));
        end
    endtask

    initial
    begin
        // hold reset, then release it away from the clock edge
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: unit pixels over a full 4096 x 4096 grid, flush past 63 entries.
        offer_point(CMD_ADD, 32'h0000_0000, 32'h0000_0000);
        offer_point(CMD_ADD, 32'h8000_0000, 32'h7FFF_FFFF);    // below origin / clamp high
        offer_point(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
        offer_point(CMD_ADD, 32'h0000_0000, 32'h0000_0000);    // repeat bin: count goes up
        offer_point(CMD_ADD, 32'h0005_8000, 32'h0003_4000);    // fractions truncate
        offer_point(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_point(CMD_FLUSH, $urandom(), $urandom());
        offer_point(CMD_FLUSH, $urandom(), $urandom());        // empty table: no beats
        drain_bins();

        // Zero width acts as one column, an oversized height as 4096 rows,
        // and a zero flush limit emits every new entry at once.
        set_grid(32'hFFF6_0000, 32'h0014_0000, 32'h0002_0000, GRID_W'(0), GRID_W'(8191),
                 LIMIT_W'(0));
        offer_point(CMD_ADD, 32'h0000_0000, 32'h0019_0000);
        offer_point(CMD_ADD, 32'h0000_0000, 32'h0019_0000);
        offer_point(CMD_FLUSH, $urandom(), $urandom());
        drain_bins();

        // Extreme origins and the largest scale: offsets of zero, one, two and the widest.
        set_grid(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, GRID_MAX, GRID_MAX, LIMIT_W'(2));
        offer_point(CMD_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        offer_point(CMD_ADD, 32'h8000_0000, 32'h8000_0001);
        offer_point(CMD_ADD, 32'h0000_0000, 32'h8000_0002);    // third entry passes the limit
        drain_bins();

        // Zero scale pins every point to pixel 0; a write past the last register is ignored.
        set_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, GRID_MAX, GRID_MAX, LIMIT_W'(63));
        write_reg(CFG_SPARE, $urandom());
        offer_point(CMD_ADD, 32'h1234_5678, 32'h7FFF_FFFF);
        offer_point(CMD_FLUSH, $urandom(), $urandom());
        drain_bins();

        // Small grid near the origin: plenty of repeat hits.
        set_grid($urandom_range(0, 1 << 20) - (1 << 19), $urandom_range(0, 1 << 20) - (1 << 19),
                 32'h0001_0000, GRID_W'(8), GRID_W'(8), LIMIT_W'(63));
        random_points(30, 8);
        drain_bins();

        // Long receiver hold-off with a low flush limit: the block fills, emits into a
        // stalled output and must hold off the points still being offered.
        set_grid($urandom(), $urandom(), $urandom_range(1 << 14, 1 << 18),
                 GRID_W'($urandom_range(2, 16)), GRID_W'($urandom_range(2, 16)), LIMIT_W'(3));
        hold_cycles = LONG_HOLD;
        random_points(30, 5);
        drain_bins();

        // Anything goes: random origins, scale, grid and limit.
        set_grid($urandom(), $urandom(), $urandom(), GRID_W'($urandom_range(1, 4096)),
                 GRID_W'($urandom_range(1, 4096)), LIMIT_W'($urandom_range(1, 63)));
        random_points(25, 10);
        drain_bins();

        // Last part, no idling on either side: a fine grid where nearly every point is a
        // new bin, so the table fills to all 64 entries before it empties itself.
        send_gaps = 1'b0;
        take_gaps = 1'b0;
        set_grid($urandom_range(0, 1 << 20) - (1 << 19), $urandom_range(0, 1 << 20) - (1 << 19),
                 32'h0010_0000, GRID_MAX, GRID_MAX, LIMIT_W'(63));
        offer_point(CMD_FLUSH, $urandom(), $urandom());
        random_points(70, 0);
        offer_point(CMD_FLUSH, $urandom(), $urandom());
        drain_bins();

        $display("Covered %0d point beats and %0d bin beats over %0d grid settings,",
                 points_taken, bins_taken, settings_used);
        $display("with empty flushes, clamped and zero-scale pixels and a full table emitted.");
        if (mismatches == 0 && waiting == 0)
            $display("** point_density_binning: PASSED **");
        else
            $display("** point_density_binning: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
design/pdb_pkg.sv
design/pdb_pixel.sv
design/pdb_cell.sv
design/point_density_binning.sv
tb/pdb_bin_checker.sv
tb/point_density_binning_test.sv
